FILE: hdl/card_credit_aggregation_table_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the card credit aggregation table
// Each macro expands to one labeled concurrent assertion clocked on clk
// and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CARD_CREDIT_AGGREGATION_TABLE_TOP_ASSERT_SVH
`define CARD_CREDIT_AGGREGATION_TABLE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCAT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ccat assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CCAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ccat assertion failed");

`endif

FILE: hdl/ccat_pkg.sv
// ----------------------------------------------------------------------------
// ccat_pkg
// Shared types and constants of the card credit aggregation table.
// ----------------------------------------------------------------------------
package ccat_pkg;

  localparam int ID_W   = 56;
  localparam int SUM_W  = 16;
  localparam int CRED_W = 9;
  localparam int MAXC_W = 7;

  localparam logic [MAXC_W-1:0] MAXC_RESET = 7'd64;
  localparam logic [SUM_W-1:0]  SUM_LIMIT  = 16'hFFFF;
  localparam logic [CRED_W-1:0] NO_CREDIT  = 9'h1FF;

  // Register index, taken from paddr[2]
  localparam logic REG_IDX_MAX_CARDS = 1'b0;

  localparam logic FUNC_LOG   = 1'b0;
  localparam logic FUNC_STATE = 1'b1;

  typedef enum logic [2:0] {
    ST_UPDATED    = 3'd0,
    ST_INSERTED   = 3'd1,
    ST_DROPPED    = 3'd2,
    ST_BAD_CHECK  = 3'd3,
    ST_CREDIT_SET = 3'd4,
    ST_NO_MATCH   = 3'd5
  } status_t;

  typedef struct packed {
    logic [SUM_W-1:0]  debit;
    logic [SUM_W-1:0]  refund;
    logic [CRED_W-1:0] credit;
  } row_t;

endpackage

FILE: hdl/ccat_cam.sv
// ----------------------------------------------------------------------------
// ccat_cam
// Card id store with a registered parallel compare against all filled rows.
// ----------------------------------------------------------------------------
module ccat_cam #(
  parameter int ROWS   = 64,
  parameter int RIDX_W = 6,
  parameter int CNT_W  = 7
) (
  input  logic                    clk,
  input  logic                    look_en,
  input  logic [ccat_pkg::ID_W-1:0] look_id,
  input  logic [CNT_W-1:0]        rows_used,
  input  logic                    wr_en,
  input  logic [RIDX_W-1:0]       wr_row,
  input  logic [ccat_pkg::ID_W-1:0] wr_id,
  output logic                    hit,
  output logic [RIDX_W-1:0]       hit_row
);
  import ccat_pkg::*;

  logic [ID_W-1:0] ids_r [ROWS];
  logic [ROWS-1:0] match_r;
  logic [ROWS-1:0] match_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ids_r[wr_row] <= wr_id;
    end
  end

  // Only rows below the fill count take part
  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      match_nxt[i] = (CNT_W'(i) < rows_used) && (ids_r[i] == look_id);
    end
  end

  always_ff @(posedge clk) begin
    if (look_en) begin
      match_r <= match_nxt;
    end
  end

  // Stored ids are distinct, so at most one bit is set
  always_comb begin
    hit_row = '0;
    for (int i = 0; i < ROWS; i++) begin
      if (match_r[i]) begin
        hit_row = hit_row | RIDX_W'(i);
      end
    end
  end

  assign hit = |match_r;

endmodule

FILE: hdl/card_credit_aggregation_table_top.sv
// ----------------------------------------------------------------------------
// card_credit_aggregation_table_top
// Per-card debit/refund/credit table built from checked log and state entries.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | input     | in_valid/in_stall  | func, card_id, delta, credit,
//          |           |                    | check_byte
//  out     | output    | out_valid/out_stall| status, row_index, totals,
//          |           |                    | last_credit, card_count, truncated
//  cfg     | input     | psel/penable/pready| max_cards at byte address 0
//
// An entry passes a registered id compare, row encode with memory read, then
// modify and write back; the row memory read is registered. A stalled result
// holds the block in its write-back step; a new entry is still taken while
// that result waits. Synchronous active-low reset clears the fill count,
// truncation flag and max_cards (to 64); row contents are not reset.
// ----------------------------------------------------------------------------
module card_credit_aggregation_table_top #(
  parameter int TABLE_ROWS = 64,
  parameter int ID_BYTES   = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_func,
  input  logic [55:0]           in_card_id,
  input  logic signed [7:0]     in_delta,
  input  logic [7:0]            in_credit,
  input  logic [7:0]            in_check_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_status,
  output logic [5:0]            out_row_index,
  output logic [15:0]           out_debited_total,
  output logic [15:0]           out_refund_total,
  output logic signed [8:0]     out_last_credit,
  output logic [6:0]            out_card_count,
  output logic                  out_truncated
);
  import ccat_pkg::*;

  localparam int RIDX_W = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam int CNT_W  = $clog2(TABLE_ROWS + 1);
  localparam int CMP_W  = (CNT_W > MAXC_W) ? CNT_W : MAXC_W;
  localparam int ID_USE = (ID_BYTES < 7) ? ID_BYTES : 7;
  localparam logic [ID_W-1:0] ID_MASK = ID_W'((64'd1 << (8 * ID_USE)) - 64'd1);

  typedef enum logic [1:0] {S_IDLE, S_FIND, S_MOD} state_t;

  state_t               state_r;
  logic [MAXC_W-1:0]    max_cards_r;
  logic [CNT_W-1:0]     rows_used_r;
  logic                 dropped_r;

  logic                 func_r;
  logic [ID_W-1:0]      id_r;
  logic [7:0]           dbyte_r;
  logic [7:0]           cbyte_r;
  logic                 ok_r;
  logic                 hit_r;
  logic                 new_r;
  logic [RIDX_W-1:0]    row_r;

  logic                 out_valid_r;
  status_t              status_r;
  logic [RIDX_W-1:0]    out_row_r;
  row_t                 out_data_r;
  logic                 touched_out_r;
  logic [CNT_W-1:0]     count_out_r;
  logic                 trunc_out_r;

  row_t                 row_mem [TABLE_ROWS];
  row_t                 rd_q;

  logic                 in_acc;
  logic [ID_W-1:0]      id_in;
  logic [7:0]           id_xor;
  logic                 ok_in;
  logic                 cam_hit;
  logic [RIDX_W-1:0]    cam_row;
  logic                 limit_full;
  logic                 do_ins;
  logic                 do_drop;
  logic [RIDX_W-1:0]    row_sel;
  logic                 mod_go;
  row_t                 base;
  row_t                 upd;
  logic [SUM_W:0]       debit_sum;
  logic [SUM_W:0]       refund_sum;
  logic [8:0]           mag;
  logic                 touched;
  status_t              status_nxt;
  logic                 cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_MAX_CARDS);
  assign prdata = (paddr[2] == REG_IDX_MAX_CARDS) ? 32'(max_cards_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cards_r <= MAXC_RESET;
    end else if (cfg_wr) begin
      max_cards_r <= pwdata[MAXC_W-1:0];
    end
  end

  // Input side
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign id_in    = in_card_id & ID_MASK;

  always_comb begin
    id_xor = '0;
    for (int i = 0; i < ID_USE; i++) begin
      id_xor = id_xor ^ id_in[8*i +: 8];
    end
  end

  assign ok_in = ((id_xor ^ ((in_func == FUNC_STATE) ? in_credit : in_delta))
                  == in_check_byte);

  ccat_cam #(
    .ROWS   (TABLE_ROWS),
    .RIDX_W (RIDX_W),
    .CNT_W  (CNT_W)
  ) u_cam (
    .clk       (clk),
    .look_en   (in_acc),
    .look_id   (id_in),
    .rows_used (rows_used_r),
    .wr_en     (do_ins),
    .wr_row    (row_sel),
    .wr_id     (id_r),
    .hit       (cam_hit),
    .hit_row   (cam_row)
  );

  // Find step: choose a row, insert or drop
  assign limit_full = (rows_used_r >= CNT_W'(TABLE_ROWS)) ||
                      (CMP_W'(rows_used_r) >= CMP_W'(max_cards_r));
  assign do_ins  = (state_r == S_FIND) && ok_r && (func_r == FUNC_LOG) &&
                   !cam_hit && !limit_full;
  assign do_drop = (state_r == S_FIND) && ok_r && (func_r == FUNC_LOG) &&
                   !cam_hit && limit_full;
  assign row_sel = do_ins ? rows_used_r[RIDX_W-1:0] : cam_row;

  // Row memory: one read, one write per cycle
  always_ff @(posedge clk) begin
    if (state_r == S_FIND) begin
      rd_q <= row_mem[row_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (mod_go && touched) begin
      row_mem[row_r] <= upd;
    end
  end

  // Modify step
  assign mod_go  = (state_r == S_MOD) && !(out_valid_r && out_stall);
  assign touched = ok_r && (hit_r || new_r);
  assign mag     = 9'd256 - {1'b0, dbyte_r};

  always_comb begin
    base = rd_q;
    if (new_r) begin
      base.debit  = '0;
      base.refund = '0;
      base.credit = NO_CREDIT;
    end
    upd        = base;
    debit_sum  = {1'b0, base.debit} + (SUM_W+1)'(mag);
    refund_sum = {1'b0, base.refund} + (SUM_W+1)'(dbyte_r);
    if (func_r == FUNC_STATE) begin
      upd.credit = {1'b0, cbyte_r};
    end else if (dbyte_r[7]) begin
      // skip, do not saturate, on overflow
      if (debit_sum <= {1'b0, SUM_LIMIT}) begin
        upd.debit = debit_sum[SUM_W-1:0];
      end
    end else if (dbyte_r != 8'd0) begin
      if (refund_sum <= {1'b0, SUM_LIMIT}) begin
        upd.refund = refund_sum[SUM_W-1:0];
      end
    end
  end

  always_comb begin
    priority if (!ok_r) begin
      status_nxt = ST_BAD_CHECK;
    end else if (func_r == FUNC_LOG) begin
      priority if (hit_r) status_nxt = ST_UPDATED;
      else if (new_r)     status_nxt = ST_INSERTED;
      else                status_nxt = ST_DROPPED;
    end else begin
      status_nxt = hit_r ? ST_CREDIT_SET : ST_NO_MATCH;
    end
  end

  // Sequencer, item registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_used_r <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (mod_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            func_r  <= in_func;
            id_r    <= id_in;
            dbyte_r <= in_delta;
            cbyte_r <= in_credit;
            ok_r    <= ok_in;
            state_r <= S_FIND;
          end
        end
        S_FIND: begin
          hit_r <= cam_hit;
          new_r <= do_ins;
          row_r <= row_sel;
          if (do_ins) begin
            rows_used_r <= rows_used_r + CNT_W'(1);
          end
          if (do_drop) begin
            dropped_r <= 1'b1;
          end
          state_r <= S_MOD;
        end
        S_MOD: begin
          if (mod_go) begin
            status_r      <= status_nxt;
            out_row_r     <= row_r;
            out_data_r    <= upd;
            touched_out_r <= touched;
            // capture the counters with the result; a later entry may move them
            count_out_r   <= rows_used_r;
            trunc_out_r   <= dropped_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_row_index     = touched_out_r ? 6'(out_row_r) : 6'd0;
  assign out_debited_total = touched_out_r ? out_data_r.debit : '0;
  assign out_refund_total  = touched_out_r ? out_data_r.refund : '0;
  assign out_last_credit   = touched_out_r ? out_data_r.credit : '0;
  assign out_card_count    = 7'(count_out_r);
  assign out_truncated     = trunc_out_r;

endmodule

FILE: hdl/ccat_checker.sv
// ----------------------------------------------------------------------------
// ccat_checker
// Port-level checks on the result channel of the card table.
// ----------------------------------------------------------------------------
`include "card_credit_aggregation_table_top_assert.svh"

module ccat_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [2:0]        out_status,
  input logic [5:0]        out_row_index,
  input logic [15:0]       out_debited_total,
  input logic [15:0]       out_refund_total,
  input logic signed [8:0] out_last_credit,
  input logic [6:0]        out_card_count,
  input logic              out_truncated
);
  import ccat_pkg::*;

  logic [57:0] out_bus;
  logic        no_row;
  logic        row_zero;
  logic        fresh_row;

  assign out_bus   = {out_status, out_row_index, out_debited_total, out_refund_total,
                      out_last_credit, out_card_count, out_truncated};
  assign no_row    = (out_status == ST_DROPPED) || (out_status == ST_BAD_CHECK) ||
                     (out_status == ST_NO_MATCH);
  assign row_zero  = (out_row_index == 6'd0) && (out_debited_total == 16'd0) &&
                     (out_refund_total == 16'd0) && (out_last_credit == 9'sd0);
  assign fresh_row = (out_last_credit == -9'sd1) &&
                     ((out_debited_total == 16'd0) || (out_refund_total == 16'd0)) &&
                     ({1'b0, out_row_index} < out_card_count);

  // Hold a stalled result
  `CCAT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_bus))

  // A dropped card always shows the truncation flag
  `CCAT_ASSERT_NOW(a_drop_flag, out_valid && (out_status == ST_DROPPED), out_truncated)

  // No row touched leaves the row fields at zero
  `CCAT_ASSERT_NOW(a_no_row_zero, out_valid && no_row, row_zero)

  // A fresh row has no credit, at most one total set, and lies below the count
  `CCAT_ASSERT_NOW(a_insert_fresh, out_valid && (out_status == ST_INSERTED), fresh_row)

endmodule

bind card_credit_aggregation_table_top ccat_checker u_ccat_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: card credit aggregation table testbench
// Drives checked log and credit state entries through the valid/stall input
// channel and compares each result against a behavioral copy of the card
// table. max_cards is set over the APB port between phases: small, zero,
// above the table size, random and full size. Both ends pause at random.
// ----------------------------------------------------------------------------
module tb_top;
  import ccat_pkg::*;

  localparam int TABLE_ROWS   = 64;
  localparam int POOL_SIZE    = 24;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_PRINTS   = 40;
  localparam logic [2:0] ADDR_MAX_CARDS = {REG_IDX_MAX_CARDS, 2'b00};
  localparam logic [2:0] ADDR_UNUSED    = {~REG_IDX_MAX_CARDS, 2'b00};

  typedef struct {
    logic        func;
    logic [55:0] id;
    logic [7:0]  delta;
    logic [7:0]  credit;
    logic [7:0]  check;
  } card_entry_t;

  typedef struct {
    status_t           status;
    logic [5:0]        row;
    logic [SUM_W-1:0]  debit;
    logic [SUM_W-1:0]  refund;
    logic [CRED_W-1:0] credit;
    logic [6:0]        count;
    logic              trunc;
  } card_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_func = 1'b0;
  logic [55:0]        in_card_id = '0;
  logic signed [7:0]  in_delta = '0;
  logic [7:0]         in_credit = '0;
  logic [7:0]         in_check_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_status;
  logic [5:0]         out_row_index;
  logic [15:0]        out_debited_total;
  logic [15:0]        out_refund_total;
  logic signed [8:0]  out_last_credit;
  logic [6:0]         out_card_count;
  logic               out_truncated;

  card_credit_aggregation_table_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_card_id        (in_card_id),
    .in_delta          (in_delta),
    .in_credit         (in_credit),
    .in_check_byte     (in_check_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_row_index     (out_row_index),
    .out_debited_total (out_debited_total),
    .out_refund_total  (out_refund_total),
    .out_last_credit   (out_last_credit),
    .out_card_count    (out_card_count),
    .out_truncated     (out_truncated)
  );

  always #5 clk = ~clk;

  // Table copy kept in step with accepted entries
  logic [55:0]       card_ids   [TABLE_ROWS];
  logic [SUM_W-1:0]  debit_sum  [TABLE_ROWS];
  logic [SUM_W-1:0]  refund_sum [TABLE_ROWS];
  logic [CRED_W-1:0] credit_val [TABLE_ROWS];
  int                rows_filled = 0;
  logic              trunc_flag = 1'b0;
  logic [MAXC_W-1:0] max_cards_cfg = MAXC_RESET;

  card_entry_t  entry_q[$];
  card_result_t result_q[$];
  logic [55:0]  card_pool [POOL_SIZE];

  logic pace_on = 1'b1;
  int   in_gap = 0;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  int   entries_sent = 0;
  int   results_seen = 0;
  int   errors = 0;

  function automatic logic [7:0] id_xor(input logic [55:0] id);
    logic [7:0] x;
    x = '0;
    for (int i = 0; i < 7; i++) x ^= id[8*i +: 8];
    return x;
  endfunction

  function automatic int find_card(input logic [55:0] id);
    for (int i = 0; i < rows_filled; i++)
      if (card_ids[i] == id) return i;
    return -1;
  endfunction

  function automatic card_result_t apply_entry(input card_entry_t e);
    card_result_t r;
    int           row;
    int           room;
    logic [8:0]   mag;
    logic [16:0]  grown;
    row = -1;
    if ((id_xor(e.id) ^ (e.func == FUNC_LOG ? e.delta : e.credit)) != e.check) begin
      r.status = ST_BAD_CHECK;
    end else if (e.func == FUNC_STATE) begin
      row = find_card(e.id);
      if (row < 0) begin
        r.status = ST_NO_MATCH;
      end else begin
        credit_val[row] = {1'b0, e.credit};
        r.status = ST_CREDIT_SET;
      end
    end else begin
      room = (max_cards_cfg < TABLE_ROWS) ? int'(max_cards_cfg) : TABLE_ROWS;
      row = find_card(e.id);
      r.status = ST_UPDATED;
      if (row < 0) begin
        if (rows_filled >= room) begin
          trunc_flag = 1'b1;
          r.status = ST_DROPPED;
        end else begin
          row = rows_filled;
          rows_filled++;
          card_ids[row]   = e.id;
          debit_sum[row]  = '0;
          refund_sum[row] = '0;
          credit_val[row] = NO_CREDIT;
          r.status = ST_INSERTED;
        end
      end
      if (row >= 0) begin
        // skip, never clip, an addition that would pass the limit
        if (e.delta[7]) begin
          mag = 9'd256 - {1'b0, e.delta};
          grown = {1'b0, debit_sum[row]} + mag;
          if (grown <= SUM_LIMIT) debit_sum[row] = grown[15:0];
        end else if (e.delta != 0) begin
          grown = {1'b0, refund_sum[row]} + e.delta;
          if (grown <= SUM_LIMIT) refund_sum[row] = grown[15:0];
        end
      end
    end
    if (row >= 0) begin
      r.row    = row[5:0];
      r.debit  = debit_sum[row];
      r.refund = refund_sum[row];
      r.credit = credit_val[row];
    end else begin
      r.row    = '0;
      r.debit  = '0;
      r.refund = '0;
      r.credit = '0;
    end
    r.count = rows_filled[6:0];
    r.trunc = trunc_flag;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (errors < MAX_PRINTS)
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic logic [55:0] rand_id();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[55:0];
  endfunction

  function automatic logic [7:0] rand_delta();
    logic [7:0] edges [4];
    edges = '{8'h80, 8'h7F, 8'h00, 8'hFF};
    if ($urandom_range(0, 7) == 0) return edges[$urandom_range(0, 3)];
    return 8'($urandom);
  endfunction

  function automatic void queue_entry(input logic func, input logic [55:0] id,
                                      input logic [7:0] delta, input logic [7:0] credit,
                                      input logic good);
    card_entry_t e;
    e.func   = func;
    e.id     = id;
    e.delta  = delta;
    e.credit = credit;
    e.check  = id_xor(id) ^ (func == FUNC_LOG ? delta : credit);
    if (!good) e.check ^= 8'($urandom_range(1, 255));
    entry_q.push_back(e);
  endfunction

  function automatic void queue_log(input logic [55:0] id, input logic [7:0] delta);
    queue_entry(FUNC_LOG, id, delta, 8'($urandom), 1'b1);
  endfunction

  function automatic void queue_state(input logic [55:0] id, input logic [7:0] credit);
    queue_entry(FUNC_STATE, id, 8'($urandom), credit, 1'b1);
  endfunction

  function automatic void queue_random_entries(input int n);
    logic [55:0] id;
    logic        func;
    int          pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) id = card_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (pick < 78)
        id = card_pool[$urandom_range(0, POOL_SIZE - 1)] ^ (56'd1 << $urandom_range(0, 55));
      else id = rand_id();
      func = ($urandom_range(0, 3) == 0) ? FUNC_STATE : FUNC_LOG;
      queue_entry(func, id, rand_delta(), 8'($urandom), $urandom_range(0, 9) != 0);
    end
  endfunction

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr[2] == REG_IDX_MAX_CARDS) max_cards_cfg = data[MAXC_W-1:0];
  endtask

  task automatic apb_check_max_cards();
    logic [31:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_MAX_CARDS;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== {25'd0, max_cards_cfg})
      report_mismatch("max_cards readback", {32'd0, got}, {57'd0, max_cards_cfg});
  endtask

  task automatic wait_drained();
    while (entry_q.size() != 0 || in_valid || result_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_max_cards(input logic [31:0] value);
    wait_drained();
    apb_write(ADDR_MAX_CARDS, value);
    apb_check_max_cards();
  endtask

  // Input driver: predict on each transfer, then load the next entry
  always @(posedge clk) begin : drive_entries
    card_entry_t taken;
    card_entry_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        taken.func   = in_func;
        taken.id     = in_card_id;
        taken.delta  = in_delta;
        taken.credit = in_credit;
        taken.check  = in_check_byte;
        result_q.push_back(apply_entry(taken));
        entries_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (entry_q.size() != 0) begin
          nxt = entry_q.pop_front();
          in_func       <= nxt.func;
          in_card_id    <= nxt.id;
          in_delta      <= nxt.delta;
          in_credit     <= nxt.credit;
          in_check_byte <= nxt.check;
          in_valid      <= 1'b1;
          if (pace_on && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall bursts
  always @(posedge clk) begin : check_results
    card_result_t want;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (result_q.size() == 0) begin
          report_mismatch("result with nothing pending", {61'd0, out_status}, 64'd0);
        end else begin
          want = result_q.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", {61'd0, out_status}, {61'd0, want.status});
          if (out_row_index !== want.row)
            report_mismatch("row_index", {58'd0, out_row_index}, {58'd0, want.row});
          if (out_debited_total !== want.debit)
            report_mismatch("debited_total", {48'd0, out_debited_total}, {48'd0, want.debit});
          if (out_refund_total !== want.refund)
            report_mismatch("refund_total", {48'd0, out_refund_total}, {48'd0, want.refund});
          if (out_last_credit !== want.credit)
            report_mismatch("last_credit", {55'd0, out_last_credit}, {55'd0, want.credit});
          if (out_card_count !== want.count)
            report_mismatch("card_count", {57'd0, out_card_count}, {57'd0, want.count});
          if (out_truncated !== want.trunc)
            report_mismatch("truncated", {63'd0, out_truncated}, {63'd0, want.trunc});
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (pace_on && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 6);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               quiet_cycles, result_q.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    logic [55:0] spill_id;
    logic [55:0] debit_card;
    logic [55:0] refund_card;
    card_pool[0] = '0;
    card_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) card_pool[i] = rand_id();
    spill_id    = rand_id();
    debit_card  = rand_id();
    refund_card = rand_id();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Small table; a write to the unused address must leave max_cards alone
    apb_check_max_cards();
    apb_write(ADDR_MAX_CARDS, 32'd4);
    apb_check_max_cards();
    apb_write(ADDR_UNUSED, 32'd0);
    apb_check_max_cards();

    queue_log(card_pool[0], 8'h00);
    queue_log(card_pool[1], 8'h80);
    queue_log(card_pool[0], 8'h7F);
    queue_log(card_pool[1], 8'hFF);
    queue_state(card_pool[0], 8'h00);
    queue_state(card_pool[1], 8'hFF);
    queue_state(spill_id, 8'h55);
    queue_entry(FUNC_LOG, card_pool[0], 8'h01, 8'h00, 1'b0);
    queue_entry(FUNC_STATE, card_pool[1], 8'h00, 8'hAA, 1'b0);
    queue_log(card_pool[2], 8'h01);
    queue_log(card_pool[3], 8'hC0);
    queue_log(spill_id, 8'h10);
    queue_state(spill_id, 8'h20);
    queue_log(spill_id, 8'h00);
    queue_log(card_pool[0], 8'h00);
    queue_state(card_pool[2], 8'd200);
    queue_state(card_pool[2], 8'd17);
    queue_log(card_pool[3], 8'h40);
    queue_entry(FUNC_LOG, spill_id, 8'h80, 8'hFF, 1'b0);
    queue_state(card_pool[3], 8'h80);

    // No room at all: filled rows still match, every new card drops
    set_max_cards(32'd0);
    queue_random_entries(60);

    // Limit past the table; push a fresh card's debit total up to the sum limit
    set_max_cards(32'd127);
    for (int i = 0; i < 511; i++) queue_log(debit_card, 8'h80);
    queue_log(debit_card, 8'h80);
    queue_log(debit_card, 8'h81);
    queue_log(debit_card, 8'hFF);
    queue_log(debit_card, 8'h05);
    queue_log(refund_card, 8'h7F);
    queue_log(refund_card, 8'h01);
    queue_log(refund_card, 8'h00);
    queue_log(refund_card, 8'hFF);
    queue_random_entries(60);

    set_max_cards($urandom_range(1, 63));
    queue_random_entries(70);

    // Full size, steady traffic to the end
    set_max_cards(32'd64);
    pace_on = 1'b0;
    queue_random_entries(80);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("tb_top: %0d entries, %0d results checked, %0d rows filled, truncated=%0b",
             entries_sent, results_seen, rows_filled, trunc_flag);
    $display("tb_top: limits 4, 0, 127, random and 64; one debit total runs into the 16-bit cap");
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: %0d mismatches", errors);
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ccat_pkg.sv
hdl/ccat_cam.sv
hdl/card_credit_aggregation_table_top.sv
hdl/ccat_checker.sv
verif/tb_top.sv
